// ===== design/drdc_pkg.sv =====
package drdc_pkg;

   localparam int SECTOR_BYTES     = 512;
   localparam int PAGE_BYTES       = 4096;
   localparam int MAX_SECTORS      = 128;
   localparam int MAX_RESULTS      = 17;

   localparam int SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
   localparam int SECTORS_PER_PAGE = PAGE_BYTES / SECTOR_BYTES;
   localparam int SPP_BITS         = $clog2(SECTORS_PER_PAGE);
   localparam int PIECE_W          = $clog2(SECTORS_PER_PAGE + 1);
   localparam int CNT_W            = $clog2(MAX_SECTORS + 1);
   localparam int NRES_W           = $clog2(MAX_RESULTS);

   localparam int BLOCK_W          = 24;
   localparam int SADDR_W          = 23;
   localparam int SPT_W            = 8;
   localparam int SPC_W            = 16;
   localparam int HEADQ_W          = 16;
   localparam int DIV_STEPS        = BLOCK_W;
   localparam int STEP_W           = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTORS_PER_TRACK    = 3'd0,
      CSR_SECTORS_PER_CYLINDER = 3'd1,
      CSR_UNIT_NUMBER          = 3'd2,
      CSR_INTERRUPT_LEVEL      = 3'd3,
      CSR_INTERRUPT_VECTOR     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_CYL,
      ST_DIV_HEAD,
      ST_EMIT,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic               is_read;
      logic [23:0]        start_block;
      logic [7:0]         sector_count;
      logic [22:0]        buffer_sector_addr;
   } req_type;

   typedef struct packed {
      logic               op_read;
      logic [23:0]        cylinder;
      logic [7:0]         head;
      logic [7:0]         sector;
      logic [3:0]         piece_sectors;
      logic [19:0]        page_number;
      logic [11:0]        page_offset;
      logic [1:0]         unit;
      logic [2:0]         irq_level;
      logic [7:0]         irq_vector;
      logic               last;
   } rsp_type;

endpackage

// ===== design/disk_request_descriptor_chainer.sv =====
// Splits one disk transfer request into page-bounded pieces and emits one command
// descriptor per piece, with the cylinder/head/sector of the piece's first block.
// A request is taken only while the block is idle; it then runs a bit-serial
// restoring divider twice (block / sectors_per_cylinder, then remainder /
// sectors_per_track), and walks the geometry forward one sector a cycle between
// descriptors. A sector count above 128 is clamped to 128, and a request yields at
// most 17 descriptors; a zero-length request emits nothing. The result register
// lets a new request start while the last descriptor still waits to be taken.
module disk_request_descriptor_chainer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  drdc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output drdc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [drdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [drdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int BW  = drdc_pkg::BLOCK_W;
   localparam int SW  = drdc_pkg::SADDR_W;
   localparam int CW  = drdc_pkg::SPC_W;
   localparam int TW  = drdc_pkg::SPT_W;
   localparam int HW  = drdc_pkg::HEADQ_W;
   localparam int PW  = drdc_pkg::PIECE_W;
   localparam int NW  = drdc_pkg::CNT_W;
   localparam int RW  = drdc_pkg::NRES_W;
   localparam int QW  = drdc_pkg::STEP_W;

   logic [TW-1:0]  spt_ff;
   logic [CW-1:0]  spc_ff;
   logic [1:0]     unit_ff;
   logic [2:0]     irq_level_ff;
   logic [7:0]     irq_vector_ff;
   logic [TW-1:0]  spt_eff;
   logic [CW-1:0]  spc_eff;

   drdc_pkg::state_type state_ff, state_in;

   logic           rd_ff, rd_in;
   logic [BW-1:0]  block_ff, block_in;
   logic [SW-1:0]  saddr_ff, saddr_in;
   logic [NW-1:0]  remain_ff, remain_in;
   logic [RW-1:0]  nres_ff, nres_in;
   logic [PW-1:0]  step_cnt_ff, step_cnt_in;
   logic [QW-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [BW-1:0]  dvd_ff, dvd_in;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [BW-1:0]  cyl_ff, cyl_in;
   logic [CW-1:0]  within_ff, within_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [TW-1:0]  sector_ff, sector_in;

   logic                rsp_valid_ff, rsp_valid_in;
   drdc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [CW:0]    shifted;
   logic [CW-1:0]  divisor;
   logic           div_ge;
   logic [CW-1:0]  div_rem;
   logic [PW-1:0]  room;
   logic [PW-1:0]  piece;
   logic [NW-1:0]  remain_after;
   logic           final_piece;
   logic           out_free;
   logic [NW-1:0]  count_sat;

   assign spt_eff   = (spt_ff == '0) ? TW'(1) : spt_ff;
   assign spc_eff   = (spc_ff == '0) ? CW'(1) : spc_ff;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != drdc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff        <= TW'(1);
         spc_ff        <= CW'(1);
         unit_ff       <= '0;
         irq_level_ff  <= '0;
         irq_vector_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            drdc_pkg::CSR_SECTORS_PER_TRACK:    spt_ff        <= csr_wdata[TW-1:0];
            drdc_pkg::CSR_SECTORS_PER_CYLINDER: spc_ff        <= csr_wdata[CW-1:0];
            drdc_pkg::CSR_UNIT_NUMBER:          unit_ff       <= csr_wdata[1:0];
            drdc_pkg::CSR_INTERRUPT_LEVEL:      irq_level_ff  <= csr_wdata[2:0];
            drdc_pkg::CSR_INTERRUPT_VECTOR:     irq_vector_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // bit-serial restoring divider step
   always_comb begin
      divisor = (state_ff == drdc_pkg::ST_DIV_CYL) ? spc_eff : CW'(spt_eff);
      shifted = {rem_ff, dvd_ff[BW-1]};
      div_ge  = (shifted >= {1'b0, divisor});
      div_rem = div_ge ? CW'(shifted - {1'b0, divisor}) : shifted[CW-1:0];
   end

   // piece length up to the next page boundary
   always_comb begin
      room         = PW'(drdc_pkg::SECTORS_PER_PAGE)
                     - PW'(saddr_ff[drdc_pkg::SPP_BITS-1:0]);
      piece        = (remain_ff < NW'(room)) ? PW'(remain_ff) : room;
      remain_after = remain_ff - NW'(piece);
      final_piece  = (remain_after == '0) || (nres_ff == RW'(drdc_pkg::MAX_RESULTS - 1));
      out_free     = !rsp_valid_ff || !rsp_stall;
      count_sat    = (req_data.sector_count > 8'(drdc_pkg::MAX_SECTORS))
                     ? NW'(drdc_pkg::MAX_SECTORS) : NW'(req_data.sector_count);
   end

   always_comb begin
      state_in     = state_ff;
      rd_in        = rd_ff;
      block_in     = block_ff;
      saddr_in     = saddr_ff;
      remain_in    = remain_ff;
      nres_in      = nres_ff;
      step_cnt_in  = step_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cyl_in       = cyl_ff;
      within_in    = within_ff;
      head_in      = head_ff;
      sector_in    = sector_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         drdc_pkg::ST_IDLE: begin
            if (req_valid) begin
               rd_in      = req_data.is_read;
               block_in   = req_data.start_block;
               saddr_in   = req_data.buffer_sector_addr;
               remain_in  = count_sat;
               nres_in    = '0;
               dvd_in     = req_data.start_block;
               rem_in     = '0;
               bit_cnt_in = '0;
               if (count_sat != '0) begin
                  state_in = drdc_pkg::ST_DIV_CYL;
               end
            end
         end
         drdc_pkg::ST_DIV_CYL: begin
            dvd_in     = {dvd_ff[BW-2:0], div_ge};
            rem_in     = div_rem;
            bit_cnt_in = bit_cnt_ff + QW'(1);
            if (bit_cnt_ff == QW'(drdc_pkg::DIV_STEPS - 1)) begin
               cyl_in     = {dvd_ff[BW-2:0], div_ge};
               within_in  = div_rem;
               dvd_in     = BW'(div_rem);
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = drdc_pkg::ST_DIV_HEAD;
            end
         end
         drdc_pkg::ST_DIV_HEAD: begin
            dvd_in     = {dvd_ff[BW-2:0], div_ge};
            rem_in     = div_rem;
            bit_cnt_in = bit_cnt_ff + QW'(1);
            if (bit_cnt_ff == QW'(drdc_pkg::DIV_STEPS - 1)) begin
               head_in   = HW'({dvd_ff[BW-2:0], div_ge});
               sector_in = div_rem[TW-1:0];
               state_in  = drdc_pkg::ST_EMIT;
            end
         end
         drdc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.op_read       = rd_ff;
               rsp_data_in.cylinder      = cyl_ff;
               rsp_data_in.head          = (|head_ff[HW-1:8]) ? 8'hFF : head_ff[7:0];
               rsp_data_in.sector        = sector_ff;
               rsp_data_in.piece_sectors = 4'(piece);
               rsp_data_in.page_number   = 20'(saddr_ff >> drdc_pkg::SPP_BITS);
               rsp_data_in.page_offset   = 12'({saddr_ff[drdc_pkg::SPP_BITS-1:0],
                                                {drdc_pkg::SECTOR_SHIFT{1'b0}}});
               rsp_data_in.unit          = unit_ff;
               rsp_data_in.irq_level     = irq_level_ff;
               rsp_data_in.irq_vector    = irq_vector_ff;
               rsp_data_in.last          = final_piece;
               remain_in                 = remain_after;
               nres_in                   = nres_ff + RW'(1);
               step_cnt_in               = piece;
               state_in = final_piece ? drdc_pkg::ST_IDLE : drdc_pkg::ST_STEP;
            end
         end
         drdc_pkg::ST_STEP: begin
            // advance geometry and buffer by one sector
            block_in    = block_ff + BW'(1);
            saddr_in    = saddr_ff + SW'(1);
            step_cnt_in = step_cnt_ff - PW'(1);
            priority if (block_ff == '1) begin
               cyl_in    = '0;
               within_in = '0;
               head_in   = '0;
               sector_in = '0;
            end else if (within_ff + CW'(1) == spc_eff) begin
               cyl_in    = cyl_ff + BW'(1);
               within_in = '0;
               head_in   = '0;
               sector_in = '0;
            end else if (sector_ff + TW'(1) == spt_eff) begin
               within_in = within_ff + CW'(1);
               head_in   = head_ff + HW'(1);
               sector_in = '0;
            end else begin
               within_in = within_ff + CW'(1);
               sector_in = sector_ff + TW'(1);
            end
            if (step_cnt_ff == PW'(1)) begin
               state_in = drdc_pkg::ST_EMIT;
            end
         end
         default: state_in = drdc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drdc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff       <= rd_in;
      block_ff    <= block_in;
      saddr_ff    <= saddr_in;
      remain_ff   <= remain_in;
      nres_ff     <= nres_in;
      step_cnt_ff <= step_cnt_in;
      bit_cnt_ff  <= bit_cnt_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cyl_ff      <= cyl_in;
      within_ff   <= within_in;
      head_ff     <= head_in;
      sector_ff   <= sector_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
